[rtl/quoted_word_splitter_core_defines.svh]
// ----------------------------------------------------------------------------
// quoted_word_splitter_core_defines.svh
// Assertion macros shared by the word splitter RTL.
// ----------------------------------------------------------------------------
`ifndef QUOTED_WORD_SPLITTER_CORE_DEFINES_SVH
`define QUOTED_WORD_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define QWS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define QWS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/qws_pkg.sv]
// ----------------------------------------------------------------------------
// qws_pkg
// Types and constants of the quoted word splitter.
// ----------------------------------------------------------------------------
package qws_pkg;

   // result kinds
   localparam logic [2:0] KIND_BYTE = 3'd0;
   localparam logic [2:0] KIND_WEND = 3'd1;
   localparam logic [2:0] KIND_LEND = 3'd2;
   localparam logic [2:0] KIND_LESC = 3'd3;
   localparam logic [2:0] KIND_LQUO = 3'd4;

   // characters of interest
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   // result queue between the step logic and the rsp port
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int QUEUE_ROOM  = QUEUE_DEPTH - 2;

   typedef enum logic [1:0] {
      QUOTE_NONE   = 2'd0,
      QUOTE_DOUBLE = 2'd1,
      QUOTE_SINGLE = 2'd2
   } quote_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_line;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] kind;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic      in_word;
      logic      escape_pending;
      quote_type open_quote;
   } state_type;

   // results of one item: count 0..2, res0 first
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type res0;
      rsp_item_type res1;
   } step_out_type;

endpackage

[rtl/qws_step.sv]
// ----------------------------------------------------------------------------
// qws_step
// Combinational splitter step: state and one item in, next state and up to
// two results out.
// ----------------------------------------------------------------------------
module qws_step (
   input  qws_pkg::state_type    state,
   input  qws_pkg::req_item_type item,
   output qws_pkg::state_type    state_next,
   output qws_pkg::step_out_type result
);

   logic [7:0]         c;
   logic               is_sep;
   qws_pkg::quote_type q;
   logic [7:0]         close_char;

   assign c = item.char_in;
   assign is_sep = c inside {qws_pkg::CHAR_SPACE, qws_pkg::CHAR_TAB,
                             qws_pkg::CHAR_LF, qws_pkg::CHAR_CR};

   always_comb begin
      case (c)
         qws_pkg::CHAR_DQUOTE: q = qws_pkg::QUOTE_DOUBLE;
         qws_pkg::CHAR_SQUOTE: q = qws_pkg::QUOTE_SINGLE;
         default:              q = qws_pkg::QUOTE_NONE;
      endcase
   end

   always_comb begin
      case (state.open_quote)
         qws_pkg::QUOTE_DOUBLE: close_char = qws_pkg::CHAR_DQUOTE;
         default:               close_char = qws_pkg::CHAR_SQUOTE;
      endcase
   end

   always_comb begin
      state_next         = state;
      result.count       = 2'd0;
      result.res0        = '{out_byte: 8'd0, kind: qws_pkg::KIND_BYTE, last: 1'b0};
      result.res1        = '{out_byte: 8'd0, kind: qws_pkg::KIND_BYTE, last: 1'b0};
      if (item.end_of_line) begin
         if (state.escape_pending) begin
            result.res0.kind = qws_pkg::KIND_LESC;
            result.count     = 2'd1;
         end else if (state.in_word && (state.open_quote != qws_pkg::QUOTE_NONE)) begin
            result.res0.kind = qws_pkg::KIND_LQUO;
            result.count     = 2'd1;
         end else if (state.in_word) begin
            result.res0.kind = qws_pkg::KIND_WEND;
            result.res1.kind = qws_pkg::KIND_LEND;
            result.count     = 2'd2;
         end else begin
            result.res0.kind = qws_pkg::KIND_LEND;
            result.count     = 2'd1;
         end
         state_next = '{in_word: 1'b0, escape_pending: 1'b0,
                        open_quote: qws_pkg::QUOTE_NONE};
      end else if (state.escape_pending) begin
         state_next.escape_pending = 1'b0;
         state_next.in_word        = 1'b1;
         result.res0.out_byte      = c;
         result.count              = 2'd1;
      end else if (c == qws_pkg::CHAR_BACKSLASH) begin
         state_next.escape_pending = 1'b1;
         state_next.in_word        = 1'b1;
      end else if (!state.in_word) begin
         if (is_sep) begin
            // separator between words: drop
         end else if (q != qws_pkg::QUOTE_NONE) begin
            state_next.in_word    = 1'b1;
            state_next.open_quote = q;
         end else begin
            state_next.in_word   = 1'b1;
            result.res0.out_byte = c;
            result.count         = 2'd1;
         end
      end else if (state.open_quote != qws_pkg::QUOTE_NONE) begin
         if (c == close_char) begin
            state_next.in_word    = 1'b0;
            state_next.open_quote = qws_pkg::QUOTE_NONE;
            result.res0.kind      = qws_pkg::KIND_WEND;
            result.count          = 2'd1;
         end else begin
            result.res0.out_byte = c;
            result.count         = 2'd1;
         end
      end else begin
         if (is_sep) begin
            state_next.in_word = 1'b0;
            result.res0.kind   = qws_pkg::KIND_WEND;
            result.count       = 2'd1;
         end else if (q != qws_pkg::QUOTE_NONE) begin
            // quote right after an unquoted word ends it and opens a span
            state_next.open_quote = q;
            result.res0.kind      = qws_pkg::KIND_WEND;
            result.count          = 2'd1;
         end else begin
            result.res0.out_byte = c;
            result.count         = 2'd1;
         end
      end
      if (result.count == 2'd1) begin
         result.res0.last = 1'b1;
      end
      if (result.count == 2'd2) begin
         result.res1.last = 1'b1;
      end
   end

endmodule

[rtl/qws_rsp_queue.sv]
// ----------------------------------------------------------------------------
// qws_rsp_queue
// Shifting result queue: takes up to two results a cycle, presents the
// oldest on the rsp port.
// ----------------------------------------------------------------------------
module qws_rsp_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push_en,
   input  qws_pkg::step_out_type              push_data,
   output logic [qws_pkg::QUEUE_CNT_W-1:0]    level,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output qws_pkg::rsp_item_type              rsp_item
);

   qws_pkg::rsp_item_type slot_ff [qws_pkg::QUEUE_DEPTH];
   qws_pkg::rsp_item_type slot_in [qws_pkg::QUEUE_DEPTH];
   logic [qws_pkg::QUEUE_CNT_W-1:0] count_ff;
   logic [qws_pkg::QUEUE_CNT_W-1:0] count_in;
   logic [qws_pkg::QUEUE_CNT_W-1:0] base_cnt;
   logic [1:0]                      n_push;
   logic                            pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = slot_ff[0];
   assign level     = count_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign n_push    = push_en ? push_data.count : 2'd0;
   assign base_cnt  = count_ff - qws_pkg::QUEUE_CNT_W'(pop);
   assign count_in  = base_cnt + qws_pkg::QUEUE_CNT_W'(n_push);

   always_comb begin
      for (int i = 0; i < qws_pkg::QUEUE_DEPTH; i++) begin
         // advance on pop, then append behind the survivors
         if (pop) begin
            slot_in[i] = slot_ff[(i + 1 < qws_pkg::QUEUE_DEPTH) ? i + 1 : i];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if ((n_push != 2'd0) && (base_cnt == qws_pkg::QUEUE_CNT_W'(i))) begin
            slot_in[i] = push_data.res0;
         end
         if ((n_push == 2'd2) &&
             ((base_cnt + qws_pkg::QUEUE_CNT_W'(1)) == qws_pkg::QUEUE_CNT_W'(i))) begin
            slot_in[i] = push_data.res1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < qws_pkg::QUEUE_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule

[rtl/quoted_word_splitter_core.sv]
// ----------------------------------------------------------------------------
// quoted_word_splitter_core
// Shell-style word splitter with quotes and backslash escapes.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one item per character (char_in) or an end-of-line marker.
//   rsp channel: word bytes, word-end marks and line-end codes; last flags
//   the final result of an input item. Separators and opening quotes between
//   words and escaping backslashes give no result.
//   An accepted item waits in the input register, is stepped once the queue
//   has room, and its results are registered into the queue before rsp_valid.
//   Throughput: one item per cycle while each gives at most one result and
//   rsp_ready stays high; an end of line that closes a word gives two
//   results for the rsp port. The rate is set by the single rsp port.
//   A four-entry result queue decouples the sides: items keep flowing while
//   results wait, and req_ready drops only when the queue lacks room for
//   two results and the input register is full.
//   Reset clears the splitter state (between words, no escape, no quote),
//   the input register and the queue. Any end of line returns the state to
//   the same values.
// ----------------------------------------------------------------------------
`include "quoted_word_splitter_core_defines.svh"

module quoted_word_splitter_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  qws_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output qws_pkg::rsp_item_type rsp_item
);

   qws_pkg::state_type    state_ff;
   qws_pkg::state_type    state_in;
   qws_pkg::state_type    step_state;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   qws_pkg::req_item_type in_item_ff;
   qws_pkg::step_out_type step_out;
   logic [qws_pkg::QUEUE_CNT_W-1:0] level;
   logic                  req_fire;
   logic                  proc_fire;

   assign proc_fire = in_valid_ff && (level <= qws_pkg::QUEUE_CNT_W'(qws_pkg::QUEUE_ROOM));
   assign req_ready = !in_valid_ff || proc_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end
      state_in = proc_fire ? step_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '{in_word: 1'b0, escape_pending: 1'b0,
                          open_quote: qws_pkg::QUOTE_NONE};
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
   end

   qws_step u_step (
      .state      (state_ff),
      .item       (in_item_ff),
      .state_next (step_state),
      .result     (step_out)
   );

   qws_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (proc_fire),
      .push_data (step_out),
      .level     (level),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   `QWS_ASSERT_IMPL(a_esc_in_word, state_ff.escape_pending, state_ff.in_word,
      "escape pending outside a word")
   `QWS_ASSERT_IMPL(a_quote_in_word, state_ff.open_quote != qws_pkg::QUOTE_NONE,
      state_ff.in_word, "quote open outside a word")
   `QWS_ASSERT_NEXT(a_eol_clears, proc_fire && in_item_ff.end_of_line,
      !state_ff.in_word && !state_ff.escape_pending &&
      (state_ff.open_quote == qws_pkg::QUOTE_NONE), "state not cleared at line end")
   `QWS_ASSERT_IMPL(a_eol_result, proc_fire && in_item_ff.end_of_line,
      step_out.count != 2'd0, "line end produced no result")
   `QWS_ASSERT_NEXT(a_push_shows, proc_fire && (step_out.count != 2'd0),
      rsp_valid, "pushed result not presented")

endmodule
